// ----- design/sns_pkg.sv -----
// Shared constants, register codes and the quarter-wave sine table
// for the sine-series solid noise pipeline. No dependencies.
`timescale 1ns / 1ps
package sns_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int TAB_BITS         = $clog2(SINE_TABLE_DEPTH);
	localparam int QTR_BITS         = TAB_BITS - 2;
	localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;
	localparam int PIPE_DEPTH       = 19;

	localparam logic [37:0] TURN_K      = 38'd174992710548;
	localparam logic [37:0] TURN_K_D135 = 38'd129624230035;
	localparam logic [15:0] INV_117     = 16'd56014;
	localparam logic [20:0] NORM_NUM    = 21'd1601613;
	localparam logic [23:0] NORM_DIV    = 24'd10218313;
	localparam logic [63:0] NORM_RECIP_W = (64'd1 << 40) / 64'd10218313;
	localparam logic [16:0] NORM_RECIP  = NORM_RECIP_W[16:0];
	localparam logic [63:0] NORM_ROUND_W = 64'd10218313 << 14;
	localparam logic [37:0] NORM_ROUND  = NORM_ROUND_W[37:0];

	typedef enum logic {
		REG_FREQUENCY  = 1'b0,
		REG_PHASE_GAIN = 1'b1
	} cfg_reg_t;

	typedef logic [14:0] qsin_t;
	typedef qsin_t qsin_tab_t [QTR_DEPTH+1];

	function automatic qsin_tab_t build_qsin();
		qsin_tab_t tab;
		logic [63:0] t, x, x2, acc, mag;
		for (int k = 0; k <= QTR_DEPTH; k++) begin
			t   = 64'(k) << (30 - QTR_BITS);
			x   = (t * 64'd1686629713) >> 30;
			x2  = (x * x) >> 30;
			acc = 64'd1073741824 - x2 / 64'd72;
			acc = 64'd1073741824 - ((x2 * acc) >> 30) / 64'd42;
			acc = 64'd1073741824 - ((x2 * acc) >> 30) / 64'd20;
			acc = 64'd1073741824 - ((x2 * acc) >> 30) / 64'd6;
			mag = (((x * acc) >> 30) + 64'd16384) >> 15;
			if (mag > 64'd32767) begin
				mag = 64'd32767;
			end
			tab[k] = mag[14:0];
		end
		return tab;
	endfunction

	localparam qsin_tab_t QSIN_TAB = build_qsin();

endpackage

// ----- design/sns_turn.sv -----
// Radians-to-turns converter: floor(a*k/2^40) mod 2^32, three stages.
// Depends on sns_pkg.
`timescale 1ns / 1ps
module sns_turn import sns_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [47:0] a,
	input  logic        [37:0] k,
	output logic        [31:0] turn
);
	logic        [42:0] p_ll_c, p_lh_c;
	logic signed [43:0] p_hl_c, p_hh_c;
	logic        [42:0] p_ll_s1, p_lh_s1;
	logic signed [43:0] p_hl_s1, p_hh_s1;
	logic        [42:0] p_ll_s2;
	logic signed [43:0] p_hh_s2;
	logic signed [49:0] mid_c, mid_s2;
	logic        [71:0] total_c;

	assign p_ll_c = a[23:0] * k[18:0];
	assign p_lh_c = a[23:0] * k[37:19];
	assign p_hl_c = $signed(a[47:24]) * $signed({1'b0, k[18:0]});
	assign p_hh_c = $signed(a[47:24]) * $signed({1'b0, k[37:19]});

	assign mid_c = $signed({p_hl_s1[43], p_hl_s1, 5'b0}) + $signed({7'b0, p_lh_s1});

	assign total_c = {p_hh_s2[28:0], 43'b0} + {{3{mid_s2[49]}}, mid_s2, 19'b0}
		+ {29'b0, p_ll_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			p_ll_s1 <= p_ll_c;
			p_lh_s1 <= p_lh_c;
			p_hl_s1 <= p_hl_c;
			p_hh_s1 <= p_hh_c;
			p_ll_s2 <= p_ll_s1;
			p_hh_s2 <= p_hh_s1;
			mid_s2  <= mid_c;
			turn    <= total_c[71:40];
		end
	end
endmodule

// ----- design/sns_sine.sv -----
// Table sine of a turn index, Q1.15, by quadrant symmetry, registered.
// Depends on sns_pkg (QSIN_TAB).
`timescale 1ns / 1ps
module sns_sine import sns_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic [TAB_BITS-1:0]       idx,
	output logic signed [15:0]        sin_q
);
	logic [1:0]          quad;
	logic [QTR_BITS-1:0] low;
	logic [QTR_BITS:0]   k;
	qsin_t               mag;

	assign quad = idx[TAB_BITS-1:TAB_BITS-2];
	assign low  = idx[QTR_BITS-1:0];
	assign k    = quad[0] ? ((QTR_BITS+1)'(QTR_DEPTH) - {1'b0, low}) : {1'b0, low};
	assign mag  = QSIN_TAB[k];

	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end
endmodule

// ----- design/sns_norm.sv -----
// Maps the signed triple product onto unsigned Q0.16, five stages,
// constant division by reciprocal multiply plus one correction. Depends on sns_pkg.
`timescale 1ns / 1ps
module sns_norm import sns_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [50:0] prod,
	output logic        [15:0] res
);
	logic [50:0] absv_c;
	logic [56:0] num_c, num_s15;
	logic [57:0] rsum_c;
	logic [42:0] m_s16, m_s17;
	logic [59:0] qm_c;
	logic [19:0] q0_s17, q_s18;
	logic [43:0] qd_c, rem_c;
	logic        neg_s15, neg_s16, neg_s17, neg_s18;
	logic [16:0] qc_c;
	logic signed [18:0] r_c;

	assign absv_c = prod[50] ? 51'(-prod) : prod;
	assign num_c  = absv_c[50:15] * NORM_NUM;
	assign rsum_c = {1'b0, num_s15} + {20'b0, NORM_ROUND};
	assign qm_c   = m_s16 * NORM_RECIP;
	assign qd_c   = q0_s17 * NORM_DIV;
	assign rem_c  = {1'b0, m_s17} - qd_c;
	assign qc_c   = (q_s18 > 20'd65536) ? 17'd65536 : q_s18[16:0];
	assign r_c    = neg_s18 ? (19'sd32768 - $signed({2'b0, qc_c}))
		: (19'sd32768 + $signed({2'b0, qc_c}));

	always_ff @(posedge clk) begin
		if (en) begin
			num_s15 <= num_c;
			neg_s15 <= prod[50];
			m_s16   <= rsum_c[57:15];
			neg_s16 <= neg_s15;
			m_s17   <= m_s16;
			q0_s17  <= qm_c[59:40];
			neg_s17 <= neg_s16;
			q_s18   <= q0_s17 + 20'(rem_c >= {20'b0, NORM_DIV});
			neg_s18 <= neg_s17;
			if (r_c < 0) begin
				res <= 16'd0;
			end else if (r_c > 19'sd65535) begin
				res <= 16'hFFFF;
			end else begin
				res <= r_c[15:0];
			end
		end
	end
endmodule

// ----- design/gardner_solid_noise_top.sv -----
// Top level of the sine-series solid noise pipeline.
// Depends on sns_pkg, sns_turn, sns_sine, sns_norm.
//
// channel  dir  tdata fields (low bit up)              notes
// s_       in   coord_x[31:0] coord_y[63:32] coord_z    one point per beat
// m_       out  noise_value[15:0]                       one value per beat
// cfg_     in   index 0 frequency, 1 phase_gain         write only
//
// One point per cycle sustained while the skid entry is empty.
// Depth is set by the chained multiply-split turn converters of each lane and
// the sine, product and normalize stages.
// arst_n clears all valid bits and the config registers to their defaults.
// Output register plus a skid entry; the pipeline freezes only when both hold.
`timescale 1ns / 1ps
module gardner_solid_noise_top import sns_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // coord_x, coord_y, coord_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // noise_value
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_data
);
	logic [15:0]        freq_q;
	logic signed [15:0] phase_q;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic               en;
	logic               skid_v_q;
	logic [15:0]        skid_q;
	logic [15:0]        res;

	logic signed [47:0] a_s1 [3];
	logic [31:0]        t1 [3];
	logic [31:0]        t135 [3];
	logic signed [15:0] s_s5 [3];
	logic [31:0]        t135_d [3][5];
	logic signed [15:0] sself_d [3][6];
	logic signed [31:0] ps_s6 [3];
	logic [31:0]        tps [3];
	logic [31:0]        tsum_s10 [3];
	logic signed [15:0] sin2 [3];
	logic signed [16:0] ser_s12 [3];
	logic signed [33:0] xy_c, xy_s13;
	logic signed [16:0] serz_s13;
	logic signed [50:0] prod_c, prod_s14;

	assign en       = ~skid_v_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q  <= 16'd2867;
			phase_q <= 16'sd5734;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FREQUENCY:  freq_q  <= cfg_data;
				REG_PHASE_GAIN: phase_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], s_tvalid};
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int OTH = (i + 2) % 3;
		logic signed [48:0] a_full;
		logic signed [31:0] ps_c;
		logic [14:0]        mag2;
		logic [30:0]        sc;
		logic [31:0]        sr;
		logic signed [16:0] s2;

		assign a_full = $signed({1'b0, freq_q}) * $signed(s_tdata[32*i +: 32]);
		assign ps_c   = phase_q * s_s5[OTH];
		assign mag2   = sin2[i][15] ? 15'(-sin2[i]) : sin2[i][14:0];
		assign sc     = mag2 * INV_117;
		assign sr     = {1'b0, sc} + 32'd32768;
		assign s2     = sin2[i][15] ? -$signed({1'b0, sr[31:16]}) : $signed({1'b0, sr[31:16]});

		always_ff @(posedge clk) begin
			if (en) begin
				a_s1[i]      <= a_full[47:0];
				t135_d[i][0] <= t135[i];
				for (int d = 1; d < 5; d++) begin
					t135_d[i][d] <= t135_d[i][d-1];
				end
				sself_d[i][0] <= s_s5[i];
				for (int d = 1; d < 6; d++) begin
					sself_d[i][d] <= sself_d[i][d-1];
				end
				ps_s6[i]    <= ps_c;
				tsum_s10[i] <= t135_d[i][4] + tps[i];
				ser_s12[i]  <= 17'(sself_d[i][5]) + s2;
			end
		end

		sns_turn u_turn1 (.clk(clk), .en(en), .a(a_s1[i]), .k(TURN_K), .turn(t1[i]));
		sns_turn u_turn135 (.clk(clk), .en(en), .a(a_s1[i]), .k(TURN_K_D135),
			.turn(t135[i]));
		sns_sine u_sin1 (.clk(clk), .en(en), .idx(t1[i][31 -: TAB_BITS]), .sin_q(s_s5[i]));
		sns_turn u_turnps (.clk(clk), .en(en),
			.a({{15{ps_s6[i][31]}}, ps_s6[i], 1'b0}), .k(TURN_K), .turn(tps[i]));
		sns_sine u_sin2 (.clk(clk), .en(en), .idx(tsum_s10[i][31 -: TAB_BITS]),
			.sin_q(sin2[i]));
	end

	assign xy_c   = ser_s12[0] * ser_s12[1];
	assign prod_c = xy_s13 * serz_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			xy_s13   <= xy_c;
			serz_s13 <= ser_s12[2];
			prod_s14 <= prod_c;
		end
	end

	sns_norm u_norm (.clk(clk), .en(en), .prod(prod_s14), .res(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !m_tvalid) begin
			if (skid_v_q) begin
				m_tdata  <= skid_q;
				m_tvalid <= 1'b1;
				skid_v_q <= 1'b0;
			end else if (vld_q[PIPE_DEPTH-1]) begin
				m_tdata  <= res;
				m_tvalid <= 1'b1;
			end else begin
				m_tvalid <= 1'b0;
			end
		end else if (en && vld_q[PIPE_DEPTH-1]) begin
			skid_q   <= res;
			skid_v_q <= 1'b1;
		end
	end
endmodule

// ----- design/sns_checker.sv -----
// Port-level checks for the solid noise top, attached by bind.
// Depends on gardner_solid_noise_top port names.
`timescale 1ns / 1ps
module sns_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	a_stall_cause: assert property (@(posedge clk) !s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");
endmodule

bind gardner_solid_noise_top sns_checker u_sns_checker (.*);

// ----- test/tb_gardner_solid_noise_top.sv -----
// Testbench for gardner_solid_noise_top: directed table plus random points,
// checked against an in-bench fixed-point noise predictor. Depends on sns_pkg.
`timescale 1ns / 1ps
module tb_gardner_solid_noise_top;
	import sns_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;   // coord_x, coord_y, coord_z
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // noise_value
	logic        cfg_we;
	logic        cfg_addr;
	logic [15:0] cfg_data;

	gardner_solid_noise_top dut (.*);

	logic [15:0] freq_q;
	logic signed [15:0] gain_q;
	logic [15:0] noise_q[$];
	int errors;
	int n_beats;
	int n_checked;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("gardner_solid_noise_top regression: fail");
		$finish;
	end

	function automatic logic [31:0] turns_of(longint a, longint unsigned k);
		longint unsigned lo;
		longint hi_p;
		longint unsigned s;
		lo = a & 64'hFFFFFF;
		hi_p = (a - longint'(lo)) / 16777216;
		s = longint'(unsigned'(hi_p)) * k + ((lo * k) >> 24);
		return s[47:16];
	endfunction

	function automatic int sin_tab(logic [31:0] turn);
		longint unsigned idx, u, r, x, x2, acc, mag;
		logic [1:0] quad;
		idx = ({32'd0, turn} * SINE_TABLE_DEPTH) >> 32;
		u = (idx << 32) / SINE_TABLE_DEPTH;
		quad = u[31:30];
		r = u & 64'h3FFFFFFF;
		if (quad[0]) r = 64'h40000000 - r;
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		acc = 64'h40000000 - x2 / 72;
		acc = 64'h40000000 - ((x2 * acc) >> 30) / 42;
		acc = 64'h40000000 - ((x2 * acc) >> 30) / 20;
		acc = 64'h40000000 - ((x2 * acc) >> 30) / 6;
		mag = (((x * acc) >> 30) + 16384) >> 15;
		if (mag > 32767) mag = 32767;
		return quad[1] ? -int'(mag) : int'(mag);
	endfunction

	function automatic int series_of(longint a, int s_self, int s_other);
		longint ps;
		logic [31:0] t;
		int sv, m, r;
		ps = longint'(gain_q) * s_other * 2;
		t = turns_of(a, 64'd129624230035) + turns_of(ps, 64'd174992710548);
		sv = sin_tab(t);
		m = sv < 0 ? -sv : sv;
		r = (m * 56014 + 32768) >>> 16;
		return s_self + (sv < 0 ? -r : r);
	endfunction

	function automatic logic [15:0] noise_of(logic [95:0] pt);
		longint ax, ay, az, prod, res;
		longint unsigned n, den, q;
		int sx, sy, sz;
		ax = longint'(freq_q) * longint'($signed(pt[31:0]));
		ay = longint'(freq_q) * longint'($signed(pt[63:32]));
		az = longint'(freq_q) * longint'($signed(pt[95:64]));
		sx = sin_tab(turns_of(ax, 64'd174992710548));
		sy = sin_tab(turns_of(ay, 64'd174992710548));
		sz = sin_tab(turns_of(az, 64'd174992710548));
		prod = longint'(series_of(ax, sx, sz)) * series_of(ay, sy, sx) * series_of(az, sz, sy);
		n = prod < 0 ? -prod : prod;
		den = 64'd10218313 << 15;
		q = ((n >> 15) * 64'd1601613 + den / 2) / den;
		if (q > 65536) q = 65536;
		res = prod < 0 ? 32768 - longint'(q) : 32768 + longint'(q);
		if (res < 0) res = 0;
		if (res > 65535) res = 65535;
		return res[15:0];
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FREQUENCY) freq_q = val;
		else gain_q = val;
	endtask

	// valid stays high after the beat; drain() or a next call with a gap drops it
	task automatic send_point(logic [95:0] pt);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pt;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		noise_q.push_back(noise_of(pt));
		n_beats++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (noise_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 5) @(posedge clk);
	endtask

	// receiver: random stall per result
	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (noise_q.size() == 0) begin
				$display("%0t: unexpected beat, actual %0d", $time, m_tdata);
				errors++;
			end else begin
				logic [15:0] e;
				e = noise_q.pop_front();
				n_checked++;
				if (e !== m_tdata) begin
					$display("%0t: noise_value expected %0d actual %0d", $time, e, m_tdata);
					errors++;
				end
			end
		end
	end

	typedef struct {
		logic [31:0] x, y, z;
		logic        chk;
		logic [15:0] noise;
	} row_t;

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 9) :
				32'h80000000 + $urandom_range(0, 9);
		endcase
	endfunction

	initial begin
		row_t rows[$];
		logic [15:0] fset[5];
		logic [15:0] gset[5];
		errors = 0;
		n_beats = 0;
		n_checked = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_FREQUENCY;
		cfg_data = '0;
		freq_q = 16'd2867;
		gain_q = 16'sd5734;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// origin: every series is zero, product zero, mid scale
		rows.push_back('{32'h0, 32'h0, 32'h0, 1'b1, 16'd32768});
		rows.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 16'd0});
		rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 16'd0});
		rows.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h0, 1'b0, 16'd0});
		rows.push_back('{32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 1'b0, 16'd0});
		rows.push_back('{32'h00010000, 32'h00010000, 32'h00010000, 1'b0, 16'd0});
		rows.push_back('{32'h00024000, 32'h00024000, 32'h00024000, 1'b0, 16'd0});
		rows.push_back('{32'hFFFDC000, 32'hFFFDC000, 32'hFFFDC000, 1'b0, 16'd0});
		rows.push_back('{32'h00024000, 32'hFFFDC000, 32'h00024000, 1'b0, 16'd0});
		rows.push_back('{32'hAAAAAAAA, 32'h55555555, 32'hFFFF0000, 1'b0, 16'd0});
		foreach (rows[i]) begin
			send_point({rows[i].z, rows[i].y, rows[i].x});
			if (rows[i].chk && noise_q[$] !== rows[i].noise) begin
				$display("%0t: table row %0d expected %0d actual %0d", $time, i,
					rows[i].noise, noise_q[$]);
				errors++;
			end
		end
		drain();

		// unknown index does not exist: cfg_addr is one bit wide
		fset = '{16'hFFFF, 16'h0000, 16'h1000, 16'd2867, 16'h0001};
		gset = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd5734};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_FREQUENCY, fset[ph]);
			write_reg(REG_PHASE_GAIN, gset[ph]);
			for (int k = 0; k < 10; k++)
				send_point({rows[k].z, rows[k].y, rows[k].x});
			for (int k = 0; k < 200; k++)
				send_point({rand_coord(), rand_coord(), rand_coord()});
			drain();
		end

		$display("covered %0d points over 6 register settings incl. extremes, %0d checked",
			n_beats, n_checked);
		if (errors == 0)
			$display("gardner_solid_noise_top regression: pass");
		else
			$display("gardner_solid_noise_top regression: fail");
		$finish;
	end

endmodule
